// File: src/fslbc_pkg.sv
// Package for the framed serial LED blink control block.
// Byte codes, staged command types, register indexes and reset values.
// No dependencies.
package fslbc_pkg;

  localparam int unsigned NumCh         = 3;
  localparam int unsigned BufferCharsDef = 32;
  localparam int unsigned RegW          = 8;
  localparam int unsigned CfgIdxW       = 2;

  localparam logic [7:0] MarkByte  = 8'h2A;  // '*'
  localparam logic [7:0] CharOne   = 8'h31;  // '1'
  localparam logic [7:0] CharTwo   = 8'h32;  // '2'
  localparam logic [7:0] CharThree = 8'h33;  // '3'
  localparam logic [7:0] CharFour  = 8'h34;  // '4'

  localparam logic [RegW-1:0] SlowReloadRst = 8'd50;
  localparam logic [RegW-1:0] MidReloadRst  = 8'd100;
  localparam logic [RegW-1:0] FastReloadRst = 8'd150;

  // Register indexes on the config port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLOW = 2'd0,
    CFG_MID  = 2'd1,
    CFG_FAST = 2'd2
  } cfg_idx_e;

  // Channel selected by a '1'..'3' byte, waiting for its code
  typedef enum logic [1:0] {
    CH_NONE = 2'd0,
    CH_A    = 2'd1,
    CH_B    = 2'd2,
    CH_C    = 2'd3
  } pend_ch_e;

  typedef enum logic [1:0] {
    LVL_NONE = 2'd0,
    LVL_LOW  = 2'd1,
    LVL_HIGH = 2'd2
  } lvl_e;

  typedef enum logic [2:0] {
    RATE_NONE = 3'd0,
    RATE_SLOW = 3'd1,
    RATE_MID  = 3'd2,
    RATE_FAST = 3'd3,
    RATE_STOP = 3'd4
  } rate_e;

  typedef struct packed {
    lvl_e  lvl;
    rate_e rate;
  } stage_t;

  // Effect of one channel code on what is staged for that channel.
  function automatic stage_t stage_code(stage_t cur, logic [7:0] code);
    stage_t nxt;
    nxt = cur;
    case (code)
      CharOne:   nxt.rate = RATE_SLOW;
      CharTwo:   nxt.rate = RATE_MID;
      CharThree: nxt.rate = RATE_FAST;
      CharFour: begin
        nxt.lvl  = LVL_HIGH;
        nxt.rate = RATE_STOP;
      end
      default: begin
        nxt.lvl  = LVL_LOW;
        nxt.rate = RATE_STOP;
      end
    endcase
    return nxt;
  endfunction

endpackage

// File: src/framed_serial_led_blink_control.sv
// Framed serial LED blink control: frame parser, staged commands, blink timers.
// Depends on fslbc_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   input   | in        | in_valid_i/in_stall_o | func_i, rx_byte_i
//   result  | out       | out_valid_o/out_stall_i | led_a_o, led_b_o, led_c_o, in_frame_o
//   config  | in        | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One item per cycle while the result is not stalled. Each accepted item updates the parser
// and timer state in the same edge and loads the result register; its result shows in the
// next cycle. The result register is the only stage, so a new item is taken
// whenever the result is empty or being taken in the same cycle.
// Reset clears all state but the result payload; the reload registers come up at 50/100/150.
// A stalled result holds and back-pressures the input through in_stall_o.
module framed_serial_led_blink_control #(
  parameter int unsigned BUFFER_CHARS = fslbc_pkg::BufferCharsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [fslbc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fslbc_pkg::RegW-1:0]    cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [7:0]                    rx_byte_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          led_a_o,
  output logic                          led_b_o,
  output logic                          led_c_o,
  output logic                          in_frame_o
);
  import fslbc_pkg::*;

  localparam int unsigned CharW = $clog2(BUFFER_CHARS + 1);

  // reload registers
  logic [RegW-1:0] slow_q, mid_q, fast_q;

  // frame parser state
  logic             frame_q, frame_d;
  logic [CharW-1:0] chars_q, chars_d;
  pend_ch_e         pend_q, pend_d;
  stage_t           stage_q [NumCh];
  stage_t           stage_d [NumCh];

  // per-channel timers and LEDs
  logic [RegW-1:0] reload_q [NumCh];
  logic [RegW-1:0] reload_d [NumCh];
  logic [RegW-1:0] cnt_q    [NumCh];
  logic [RegW-1:0] cnt_d    [NumCh];
  logic [NumCh-1:0] led_q, led_d;

  // result register
  logic             out_valid_q;
  logic [NumCh-1:0] out_led_q;
  logic             out_frame_q;

  logic in_acc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    stage_t          fin [NumCh];
    logic [1:0]      pidx;
    logic [RegW-1:0] dec;

    frame_d = frame_q;
    chars_d = chars_q;
    pend_d  = pend_q;
    led_d   = led_q;
    pidx    = 2'(pend_q) - 2'd1;
    dec     = '0;
    for (int k = 0; k < NumCh; k++) begin
      stage_d[k]  = stage_q[k];
      reload_d[k] = reload_q[k];
      cnt_d[k]    = cnt_q[k];
      fin[k]      = stage_q[k];
    end

    if (in_acc) begin
      if (func_i) begin
        // timer tick: decrement running counters, toggle and reload at 1
        for (int k = 0; k < NumCh; k++) begin
          if (cnt_q[k] != '0) begin
            dec = cnt_q[k] - 1'b1;
            if (dec == RegW'(1)) begin
              led_d[k] = ~led_q[k];
              cnt_d[k] = reload_q[k];
            end else begin
              cnt_d[k] = dec;
            end
          end
        end
      end else if (!frame_q) begin
        if (rx_byte_i == MarkByte) frame_d = 1'b1;
      end else if (rx_byte_i == MarkByte) begin
        // closing mark: a channel still waiting for its code goes low
        if (pend_q != CH_NONE) begin
          fin[pidx].lvl  = LVL_LOW;
          fin[pidx].rate = RATE_STOP;
        end
        for (int k = 0; k < NumCh; k++) begin
          case (fin[k].lvl)
            LVL_HIGH: led_d[k] = 1'b1;
            LVL_LOW:  led_d[k] = 1'b0;
            default:  led_d[k] = led_q[k];
          endcase
          case (fin[k].rate)
            RATE_SLOW: begin
              reload_d[k] = slow_q;
              cnt_d[k]    = slow_q;
            end
            RATE_MID: begin
              reload_d[k] = mid_q;
              cnt_d[k]    = mid_q;
            end
            RATE_FAST: begin
              reload_d[k] = fast_q;
              cnt_d[k]    = fast_q;
            end
            RATE_STOP: begin
              reload_d[k] = '0;
              cnt_d[k]    = '0;
            end
            default: ;
          endcase
          stage_d[k] = '{lvl: LVL_NONE, rate: RATE_NONE};
        end
        chars_d = '0;
        pend_d  = CH_NONE;
        frame_d = 1'b0;
      end else if (chars_q < CharW'(BUFFER_CHARS)) begin
        // bytes past the buffer are dropped
        chars_d = chars_q + 1'b1;
        if (pend_q != CH_NONE) begin
          stage_d[pidx] = stage_code(stage_q[pidx], rx_byte_i);
          pend_d        = CH_NONE;
        end else begin
          case (rx_byte_i)
            CharOne:   pend_d = CH_A;
            CharTwo:   pend_d = CH_B;
            CharThree: pend_d = CH_C;
            default:   pend_d = CH_NONE;
          endcase
        end
      end
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q <= SlowReloadRst;
      mid_q  <= MidReloadRst;
      fast_q <= FastReloadRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLOW: slow_q <= cfg_data_i;
        CFG_MID:  mid_q  <= cfg_data_i;
        CFG_FAST: fast_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= 1'b0;
      chars_q <= '0;
      pend_q  <= CH_NONE;
      led_q   <= '0;
      for (int k = 0; k < NumCh; k++) begin
        stage_q[k]  <= '{lvl: LVL_NONE, rate: RATE_NONE};
        reload_q[k] <= '0;
        cnt_q[k]    <= '0;
      end
    end else begin
      frame_q <= frame_d;
      chars_q <= chars_d;
      pend_q  <= pend_d;
      led_q   <= led_d;
      for (int k = 0; k < NumCh; k++) begin
        stage_q[k]  <= stage_d[k];
        reload_q[k] <= reload_d[k];
        cnt_q[k]    <= cnt_d[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_led_q   <= led_d;
      out_frame_q <= frame_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_a_o     = out_led_q[0];
  assign led_b_o     = out_led_q[1];
  assign led_c_o     = out_led_q[2];
  assign in_frame_o  = out_frame_q;

  // every accepted item leaves a result behind
  a_acc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted item produced no result");

  // an opening mark opens the frame and the result reports it
  a_open_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !func_i && !frame_q && rx_byte_i == MarkByte) |=> (frame_q && in_frame_o))
    else $error("opening mark did not open frame");

  // no parse state survives outside a frame
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_q |-> (chars_q == '0 && pend_q == CH_NONE))
    else $error("parse state left outside frame");

  // a running counter always has a reload to come back to
  a_cnt_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] == '0 || reload_q[0] != '0) && (cnt_q[1] == '0 || reload_q[1] != '0) &&
    (cnt_q[2] == '0 || reload_q[2] != '0))
    else $error("counter running with zero reload");

endmodule

// File: verif/fslbc_checker.sv
// Checker for the framed serial LED blink control block: watches the config port and both
// item channels, predicts the LED levels of every accepted item and compares results.
// Depends on fslbc_pkg.
module fslbc_checker #(
  parameter int unsigned BUFFER_CHARS = fslbc_pkg::BufferCharsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fslbc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fslbc_pkg::RegW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          func_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          led_a_i,
  input  logic                          led_b_i,
  input  logic                          led_c_i,
  input  logic                          in_frame_i,
  output int                            fail_cnt_o,
  output int                            pending_o
);
  import fslbc_pkg::*;

  localparam logic [7:0] NoCode = 8'h00;  // any code other than '1'..'4' holds low

  typedef struct packed {
    logic led_a;
    logic led_b;
    logic led_c;
    logic in_frame;
  } led_state_t;

  logic [RegW-1:0] slow_rld, mid_rld, fast_rld;
  logic            frame_open;
  int              chars_taken;
  pend_ch_e        pend_ch;
  lvl_e            lvl_q    [NumCh];
  rate_e           rate_q   [NumCh];
  logic [RegW-1:0] reload_q [NumCh];
  logic [RegW-1:0] count_q  [NumCh];
  logic            led_q    [NumCh];
  led_state_t      expected_leds[$];
  int              fails;

  assign fail_cnt_o = fails;

  function automatic void clear_staging();
    chars_taken = 0;
    pend_ch     = CH_NONE;
    for (int k = 0; k < NumCh; k++) begin
      lvl_q[k]  = LVL_NONE;
      rate_q[k] = RATE_NONE;
    end
  endfunction

  function automatic void stage_cmd(int ch, logic [7:0] code);
    case (code)
      CharOne:   rate_q[ch] = RATE_SLOW;
      CharTwo:   rate_q[ch] = RATE_MID;
      CharThree: rate_q[ch] = RATE_FAST;
      CharFour: begin
        lvl_q[ch]  = LVL_HIGH;
        rate_q[ch] = RATE_STOP;
      end
      default: begin
        lvl_q[ch]  = LVL_LOW;
        rate_q[ch] = RATE_STOP;
      end
    endcase
  endfunction

  function automatic logic [RegW-1:0] reload_for(rate_e r);
    case (r)
      RATE_SLOW: return slow_rld;
      RATE_MID:  return mid_rld;
      default:   return fast_rld;
    endcase
  endfunction

  // closing mark: a channel still waiting for its code goes low
  function automatic void commit_frame();
    if (pend_ch != CH_NONE) stage_cmd(int'(pend_ch) - 1, NoCode);
    for (int k = 0; k < NumCh; k++) begin
      if (lvl_q[k] == LVL_HIGH) led_q[k] = 1'b1;
      else if (lvl_q[k] == LVL_LOW) led_q[k] = 1'b0;
      if (rate_q[k] inside {RATE_SLOW, RATE_MID, RATE_FAST}) begin
        reload_q[k] = reload_for(rate_q[k]);
        count_q[k]  = reload_q[k];
      end else if (rate_q[k] == RATE_STOP) begin
        reload_q[k] = '0;
        count_q[k]  = '0;
      end
    end
    clear_staging();
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (!frame_open) begin
      if (b == MarkByte) frame_open = 1'b1;
    end else if (b == MarkByte) begin
      commit_frame();
      frame_open = 1'b0;
    end else if (chars_taken < BUFFER_CHARS) begin
      chars_taken++;
      if (pend_ch != CH_NONE) begin
        stage_cmd(int'(pend_ch) - 1, b);
        pend_ch = CH_NONE;
      end else if (b == CharOne) pend_ch = CH_A;
      else if (b == CharTwo) pend_ch = CH_B;
      else if (b == CharThree) pend_ch = CH_C;
    end
  endfunction

  function automatic void tick_timers();
    for (int k = 0; k < NumCh; k++) begin
      if (count_q[k] != '0) begin
        count_q[k]--;
        if (count_q[k] == 8'd1) begin
          led_q[k]   = ~led_q[k];
          count_q[k] = reload_q[k];
        end
      end
    end
  endfunction

  task automatic check_field(string name, logic exp_v, logic act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0b, got %0b", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    led_state_t exp_s;
    if (!rst_ni) begin
      slow_rld   = SlowReloadRst;
      mid_rld    = MidReloadRst;
      fast_rld   = FastReloadRst;
      frame_open = 1'b0;
      clear_staging();
      for (int k = 0; k < NumCh; k++) begin
        reload_q[k] = '0;
        count_q[k]  = '0;
        led_q[k]    = 1'b0;
      end
      expected_leds.delete();
      fails = 0;
    end else begin
      // results first: a result taken at this edge belongs to an older item
      if (out_valid_i && !out_stall_i) begin
        if (expected_leds.size() == 0) begin
          $display("%0t: result expected none, got leds %0b%0b%0b frame %0b", $time,
                   led_a_i, led_b_i, led_c_i, in_frame_i);
          fails++;
        end else begin
          exp_s = expected_leds.pop_front();
          check_field("led_a", exp_s.led_a, led_a_i);
          check_field("led_b", exp_s.led_b, led_b_i);
          check_field("led_c", exp_s.led_c, led_c_i);
          check_field("in_frame", exp_s.in_frame, in_frame_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SLOW: slow_rld = cfg_data_i;
          CFG_MID:  mid_rld  = cfg_data_i;
          CFG_FAST: fast_rld = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (func_i) tick_timers();
        else take_byte(rx_byte_i);
        exp_s.led_a    = led_q[0];
        exp_s.led_b    = led_q[1];
        exp_s.led_c    = led_q[2];
        exp_s.in_frame = frame_open;
        expected_leds.push_back(exp_s);
      end
    end
    pending_o = expected_leds.size();
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the framed serial LED blink control block: clock, reset, stimulus,
// random idling on both channels, watchdog and verdict.
// Depends on fslbc_pkg, framed_serial_led_blink_control and fslbc_checker.
module tb_top;
  import fslbc_pkg::*;

  localparam int unsigned BufChars = BufferCharsDef;
  localparam int ItemTarget    = 1100;  // random part stops once this many items are sent
  localparam int PhaseItems    = 140;   // items between reload changes
  localparam int MaxGap        = 17;    // longest idle or stall drawn per item
  localparam int WatchdogLimit = 400;   // cycles without any accept or register write before giving up

  logic          clk_i;
  logic          rst_ni    = 1'b0;
  logic          cfg_we    = 1'b0;
  cfg_idx_e      cfg_idx   = CFG_SLOW;
  logic [RegW-1:0] cfg_data = '0;
  logic          in_valid  = 1'b0;
  logic          func      = 1'b0;
  logic [7:0]    rx_byte   = '0;
  logic          out_stall = 1'b0;
  logic          in_stall, out_valid;
  logic          led_a, led_b, led_c, in_frame;

  int            fail_cnt;
  int            results_pending;
  int            idle_cycles;
  int            n_items         = 0;
  bit            send_idle       = 1'b1;  // sender draws gaps while set
  bit            sink_idle       = 1'b1;  // receiver draws stalls while set
  bit            frame_left_open = 1'b0;  // a broken fragment left a frame open

  framed_serial_led_blink_control #(
    .BUFFER_CHARS (BufChars)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .func_i      (func),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .led_a_o     (led_a),
    .led_b_o     (led_b),
    .led_c_o     (led_c),
    .in_frame_o  (in_frame)
  );

  fslbc_checker #(
    .BUFFER_CHARS (BufChars)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .func_i      (func),
    .rx_byte_i   (rx_byte),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .led_a_i     (led_a),
    .led_b_i     (led_b),
    .led_c_i     (led_c),
    .in_frame_i  (in_frame),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: any accept or register write counts as progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("Some tests failed");
    $finish;
  end

  // Receiver: stall drawn per result, with stretches of no stall at all.
  // Stall and valid only change at rising edges, so the falling edge sees
  // what the next rising edge will act on.
  initial begin
    int n;
    @(posedge clk_i);
    forever begin
      n = sink_idle ? $urandom_range(0, MaxGap) : 0;
      if ($urandom_range(0, 63) == 0) sink_idle = !sink_idle;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      forever begin
        @(negedge clk_i);
        if (out_valid) break;
      end
      @(posedge clk_i);
    end
  end

  // One item: optional gap with valid low, then hold the payload until taken.
  // Entered and left right after a rising edge.
  task automatic send_item(input logic f, input logic [7:0] b, input bit counts);
    int gap;
    gap = send_idle ? $urandom_range(0, MaxGap) : 0;
    if ($urandom_range(0, 49) == 0) send_idle = !send_idle;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func     <= f;
    rx_byte  <= b;
    forever begin
      @(negedge clk_i);
      if (!in_stall) break;
    end
    @(posedge clk_i);
    if (counts) n_items++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b, 1'b1);
  endtask

  // rx_byte carries junk on ticks; the block must ignore it
  task automatic send_ticks(input int n);
    repeat (n) send_item(1'b1, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Stop sending and wait until every result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (results_pending == 0) break;
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reloads(input logic [7:0] s, input logic [7:0] m, input logic [7:0] f);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SLOW;
    cfg_data <= s;
    @(posedge clk_i);
    cfg_idx  <= CFG_MID;
    cfg_data <= m;
    @(posedge clk_i);
    cfg_idx  <= CFG_FAST;
    cfg_data <= f;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] non_mark_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == MarkByte);
    return b;
  endfunction

  // Code byte: mostly blink rates and '4', the rest any other byte (holds low).
  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CharOne + 8'($urandom_range(0, 2));
    if (r < 65) return CharFour;
    return non_mark_byte();
  endfunction

  function automatic logic [7:0] pick_channel();
    return CharOne + 8'($urandom_range(0, 2));
  endfunction

  // Well formed frame: channel/code pairs, some junk, maybe a lone channel
  // or a tick in the middle.
  task automatic send_frame();
    int pairs;
    if (frame_left_open) begin
      send_byte(MarkByte);
      frame_left_open = 1'b0;
    end
    pairs = $urandom_range(0, 4);
    send_byte(MarkByte);
    for (int p = 0; p < pairs; p++) begin
      if ($urandom_range(0, 4) == 0) send_byte(non_mark_byte());
      send_byte(pick_channel());
      if ($urandom_range(0, 9) == 0) send_ticks(1);
      send_byte(pick_code());
    end
    if ($urandom_range(0, 6) == 0) send_byte(pick_channel());
    send_byte(MarkByte);
  endtask

  // Frame from two bytes short of the buffer to eight past it; bytes past the limit must be dropped.
  task automatic send_long_frame();
    int len;
    int r;
    if (frame_left_open) begin
      send_byte(MarkByte);
      frame_left_open = 1'b0;
    end
    len = $urandom_range(BufChars - 2, BufChars + 8);
    send_byte(MarkByte);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 2);
      if (r == 0) send_byte(pick_channel());
      else if (r == 1) send_byte(pick_code());
      else send_byte(non_mark_byte());
    end
    send_byte(MarkByte);
  endtask

  // Broken sequence: open a frame, a few bytes and ticks, no close.
  task automatic send_open_fragment();
    if (!frame_left_open) send_byte(MarkByte);
    frame_left_open = 1'b1;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 2) == 0) send_ticks(1);
      else send_byte($urandom_range(0, 1) ? pick_channel() : non_mark_byte());
    end
  endtask

  initial begin
    int phase;
    int phase_end;
    int r;
    logic [7:0] rs, rm, rf;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part, reset reloads ---
    send_ticks(1);                       // tick with everything idle
    send_byte(8'hFF);                    // bytes outside a frame are ignored
    send_byte(CharOne);
    send_byte(MarkByte);                 // a: high, b: slow blink, c: low
    send_byte(CharOne);   send_byte(CharFour);
    send_byte(CharTwo);   send_byte(CharOne);
    send_byte(CharThree); send_byte(8'h00);
    send_byte(MarkByte);
    send_ticks(2);
    send_byte(MarkByte);                 // c: '4' then fast blink, tick mid frame
    send_byte(CharThree); send_byte(CharFour);
    send_ticks(1);
    send_byte(CharThree); send_byte(CharThree);
    send_byte(MarkByte);
    send_byte(MarkByte);                 // lone channel at close: b low, stopped
    send_byte(CharTwo);
    send_byte(MarkByte);
    send_byte(MarkByte);                 // skipped bytes only
    send_byte(8'h78);     send_byte(8'hFF);
    send_byte(MarkByte);

    // --- random part in phases of reload settings ---
    phase = 0;
    while (n_items < ItemTarget) begin
      case (phase)
        0: begin rs = 8'd2;   rm = 8'd2;   rf = 8'd2;   end
        1: begin rs = 8'd255; rm = 8'd255; rf = 8'd255; end
        2: begin rs = 8'd255; rm = 8'd2;   rf = 8'd128; end
        default: begin
          // mostly short reloads so toggles come often
          rs = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255)) : 8'($urandom_range(2, 12));
          rm = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255)) : 8'($urandom_range(2, 12));
          rf = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255)) : 8'($urandom_range(2, 12));
        end
      endcase
      write_reloads(rs, rm, rf);
      phase_end = n_items + PhaseItems;
      while (n_items < phase_end && n_items < ItemTarget) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          send_frame();
        end else if (r < 72) begin
          // long runs let the 255 reloads wrap around
          if ($urandom_range(0, (phase == 1) ? 3 : 19) == 0) send_ticks($urandom_range(100, 260));
          else send_ticks($urandom_range(1, 12));
        end else if (r < 80) begin
          send_long_frame();
        end else if (r < 88) begin
          send_open_fragment();
        end else if (r < 92) begin
          // sender waits for the receiver to catch up completely
          drain_results();
        end else if (!frame_left_open) begin
          repeat ($urandom_range(1, 4)) send_item(1'b0, non_mark_byte(), 1'b0);
        end
      end
      phase++;
    end

    drain_results();
    repeat (5) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
